/* rtl/spq_pkg.sv */
// Shared constants, types and pointer helpers for the sorted min-priority queue.
`default_nettype none

package spq_pkg;

  localparam int unsigned CAPACITY = 16;

  localparam int unsigned VAL_W    = 32;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W    = CNT_W + 1;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t EMPTY_VALUE = {VAL_W{1'b1}};

  typedef enum logic {
    KIND_ENQUEUE = 1'b0,
    KIND_DEQUEUE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ_SCAN,
    ST_ENQ_PUT,
    ST_DEQ_WAIT,
    ST_FINISH
  } state_e;

  // Step a ring pointer forward, wrapping at the capacity.
  function automatic idx_t wrap_inc(input idx_t p);
    return (p == IDX_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

  // Step a ring pointer back, wrapping at the capacity.
  function automatic idx_t wrap_dec(input idx_t p);
    return (p == '0) ? IDX_W'(CAPACITY - 1) : p - 1'b1;
  endfunction

  // Ring position of base plus offset; offset never exceeds the capacity.
  function automatic idx_t wrap_add(input idx_t base, input cnt_t off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return IDX_W'(sum);
  endfunction

endpackage

`default_nettype wire

/* rtl/spq_if.sv */
// Valid/ready channel interfaces for queue commands and queue results.
`default_nettype none

interface spq_in_if
  import spq_pkg::*;
();
  logic  valid;
  logic  ready;
  kind_e kind;
  val_t  item_value;

  modport source (output valid, output kind, output item_value, input ready);
  modport sink   (input valid, input kind, input item_value, output ready);
endinterface

interface spq_out_if
  import spq_pkg::*;
();
  logic             valid;
  logic             ready;
  val_t             out_value;
  status_e          status;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, output out_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input out_value, input status, input occupancy,
                  output ready);
endinterface

`default_nettype wire

/* rtl/sorted_min_priority_queue.sv */
// A full enqueue, an enqueue into an empty queue and an empty dequeue go straight to the
//   result; a dequeue first waits for the registered read of the head; any other enqueue
//   walks down from the tail, one entry read and one entry moved per cycle.
// One item at a time: the next input beat is taken once the last result has been loaded
//   into the output register, so a stalled result holds off the input.
// Reset: asynchronous, active low; clears state, count, ring head and output valid, leaves the
//   entry memory unwritten (never read before it is written).
`default_nettype none

module sorted_min_priority_queue
  import spq_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  spq_in_if.sink     in_i,
  spq_out_if.source  out_o
);

  // Values live in a ring buffer in ascending order from head_q. A dequeue
  // reads the head and advances it. An enqueue walks down from the tail,
  // moving every larger value up one slot until it finds its place.

  state_e state_q, state_d;
  idx_t   head_q, head_d;
  cnt_t   count_q, count_d;
  idx_t   rd_ptr_q, rd_ptr_d;
  idx_t   wr_ptr_q, wr_ptr_d;
  cnt_t   left_q, left_d;
  val_t   val_q, val_d;
  val_t   res_value_q, res_value_d;
  status_e res_status_q, res_status_d;

  logic             out_valid_q, out_valid_d;
  val_t             out_value_q;
  status_e          out_status_q;
  logic [OCC_W-1:0] out_occ_q;
  logic             out_load;

  // Entry memory: one write port, one read port, registered read data.
  val_t mem_q [CAPACITY];
  val_t rdata_q;
  logic mem_we;
  idx_t mem_waddr;
  val_t mem_wdata;
  logic mem_re;
  idx_t mem_raddr;

  idx_t tail;
  idx_t step_back;

  assign tail      = wrap_add(head_q, count_q);
  assign step_back = wrap_dec(rd_ptr_q);

  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    left_d       = left_q;
    val_d        = val_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    mem_waddr    = wr_ptr_q;
    mem_wdata    = val_q;
    mem_re       = 1'b0;
    mem_raddr    = rd_ptr_q;
    out_load     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          if (in_i.kind == KIND_ENQUEUE) begin
            res_value_d = '0;
            if (count_q == CNT_W'(CAPACITY)) begin
              // Drop the value, report full.
              res_status_d = STATUS_FULL;
              state_d      = ST_FINISH;
            end else if (count_q == '0) begin
              res_status_d = STATUS_OK;
              mem_we       = 1'b1;
              mem_waddr    = head_q;
              mem_wdata    = in_i.item_value;
              count_d      = count_q + 1'b1;
              state_d      = ST_FINISH;
            end else begin
              // Start the walk: read the last stored value, target the tail.
              res_status_d = STATUS_OK;
              mem_re       = 1'b1;
              mem_raddr    = wrap_dec(tail);
              rd_ptr_d     = wrap_dec(tail);
              wr_ptr_d     = tail;
              left_d       = count_q;
              val_d        = in_i.item_value;
              count_d      = count_q + 1'b1;
              state_d      = ST_ENQ_SCAN;
            end
          end else begin
            if (count_q == '0) begin
              res_value_d  = EMPTY_VALUE;
              res_status_d = STATUS_EMPTY;
              state_d      = ST_FINISH;
            end else begin
              res_status_d = STATUS_OK;
              mem_re       = 1'b1;
              mem_raddr    = head_q;
              head_d       = wrap_inc(head_q);
              count_d      = count_q - 1'b1;
              state_d      = ST_DEQ_WAIT;
            end
          end
        end
      end

      ST_ENQ_SCAN: begin
        mem_we    = 1'b1;
        mem_waddr = wr_ptr_q;
        if (rdata_q > val_q) begin
          // Larger value: move it up one slot and keep walking.
          mem_wdata = rdata_q;
          wr_ptr_d  = rd_ptr_q;
          left_d    = left_q - 1'b1;
          if (left_q == CNT_W'(1)) begin
            state_d = ST_ENQ_PUT;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = step_back;
            rd_ptr_d  = step_back;
          end
        end else begin
          // Equal or smaller: the new value goes right after it.
          mem_wdata = val_q;
          state_d   = ST_FINISH;
        end
      end

      ST_ENQ_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = wr_ptr_q;
        mem_wdata = val_q;
        state_d   = ST_FINISH;
      end

      ST_DEQ_WAIT: begin
        res_value_d = rdata_q;
        state_d     = ST_FINISH;
      end

      ST_FINISH: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q     <= rd_ptr_d;
    wr_ptr_q     <= wr_ptr_d;
    left_q       <= left_d;
    val_q        <= val_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_value_q  <= res_value_q;
      out_status_q <= res_status_q;
      out_occ_q    <= OCC_W'(count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_value = out_value_q;
  assign out_o.status    = out_status_q;
  assign out_o.occupancy = out_occ_q;

endmodule

`default_nettype wire

/* rtl/spq_checker.sv */
// Port-level assertions for the sorted min-priority queue, bound to the top level.
`default_nettype none

module spq_checker
  import spq_pkg::*;
(
  input wire             clk_i,
  input wire             rst_ni,
  input wire             out_valid,
  input wire             out_ready,
  input wire [VAL_W-1:0] out_value,
  input wire [1:0]       status,
  input wire [OCC_W-1:0] occupancy
);

  // Hold a stalled result beat unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(status)
      && $stable(occupancy))
    else $error("result beat changed while stalled");

  // An empty dequeue returns -1 and leaves nothing stored.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status == STATUS_EMPTY |-> out_value == EMPTY_VALUE && occupancy == '0)
    else $error("empty result with wrong value or occupancy");

  // A dropped enqueue only happens at capacity.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status == STATUS_FULL |-> occupancy == OCC_W'(CAPACITY) && out_value == '0)
    else $error("full result below capacity");

  // Status code three is never produced.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> status == STATUS_OK || status == STATUS_FULL || status == STATUS_EMPTY)
    else $error("undefined status code");

endmodule

bind sorted_min_priority_queue spq_checker u_spq_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_value (out_o.out_value),
  .status    (out_o.status),
  .occupancy (out_o.occupancy)
);

`default_nettype wire

/* tb/sorted_min_priority_queue_test.sv */
// Self-checking bench for the sorted min-priority queue: shadow queue predictor with random stalls.
`default_nettype none

module sorted_min_priority_queue_test;
  import spq_pkg::*;

  // One command beat as the driver offers it.
  typedef struct {
    kind_e op;
    val_t  value;
  } queue_cmd_t;

  // One result beat as the shadow queue predicts it.
  typedef struct {
    val_t             value;
    status_e          status;
    logic [OCC_W-1:0] occupancy;
  } queue_result_t;

  localparam int unsigned HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 40;   // tail wait, well past the longest walk
  localparam int unsigned BATCH_ITEMS  = 650;  // random beats per idling phase
  localparam int unsigned PRINT_LIMIT  = 100;  // keep a broken run's log readable

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  spq_in_if  cmd_ch ();
  spq_out_if res_ch ();

  sorted_min_priority_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .out_o  (res_ch)
  );

  // Commands waiting to be offered, filled by the sequence process below.
  queue_cmd_t    queued_cmds[$];
  // Results predicted for accepted commands, oldest first.
  queue_result_t awaited_results[$];

  // Shadow copy of the queue contents, kept in ascending order.
  val_t shadow_vals[CAPACITY];
  int   shadow_count = 0;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_req      = 1'b0;
  int   hold_left     = 0;
  int   mismatch_count = 0;

  // 8-unit clock period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Apply one command to the shadow queue and return the result it must produce.
  function automatic queue_result_t step_shadow_queue(kind_e op, val_t value);
    queue_result_t res;
    int            pos;
    res.value  = '0;
    res.status = STATUS_OK;
    if (op == KIND_ENQUEUE) begin
      if (shadow_count >= CAPACITY) begin
        // Full: drop the value, leave the contents alone.
        res.status = STATUS_FULL;
      end else begin
        // Insert after every stored value that is less than or equal, so
        // equal values keep their arrival order.
        pos = 0;
        while (pos < shadow_count && shadow_vals[pos] <= value) pos++;
        for (int k = shadow_count; k > pos; k--) shadow_vals[k] = shadow_vals[k-1];
        shadow_vals[pos] = value;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        res.value  = EMPTY_VALUE;
        res.status = STATUS_EMPTY;
      end else begin
        // Pop the head and close the gap.
        res.value = shadow_vals[0];
        for (int k = 1; k < shadow_count; k++) shadow_vals[k-1] = shadow_vals[k];
        shadow_count--;
      end
    end
    res.occupancy = OCC_W'(shadow_count);
    return res;
  endfunction

  // Print one line per mismatch (up to a cap) and count every one.
  task automatic flag_mismatch(string msg);
    if (mismatch_count < PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Driver: hold a beat until it is taken, then offer the next one or idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_ch.valid      <= 1'b0;
      cmd_ch.kind       <= KIND_ENQUEUE;
      cmd_ch.item_value <= '0;
    end else if (!cmd_ch.valid || cmd_ch.ready) begin
      if (queued_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd_ch.valid      <= 1'b1;
        cmd_ch.kind       <= queued_cmds[0].op;
        cmd_ch.item_value <= queued_cmds[0].value;
        void'(queued_cmds.pop_front());
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      hold_left    <= 0;
    end else if (hold_req) begin
      res_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on every command beat, check every result beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        awaited_results.push_back(step_shadow_queue(cmd_ch.kind, cmd_ch.item_value));
      end
      if (res_ch.valid && res_ch.ready) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch($sformatf("result beat with none expected: value %0d status %0d",
                                  res_ch.out_value, res_ch.status));
        end else begin
          if (res_ch.out_value !== awaited_results[0].value)
            flag_mismatch($sformatf("out_value %0d, expected %0d",
                                    res_ch.out_value, awaited_results[0].value));
          if (res_ch.status !== awaited_results[0].status)
            flag_mismatch($sformatf("status %0d, expected %0d",
                                    res_ch.status, awaited_results[0].status));
          if (res_ch.occupancy !== awaited_results[0].occupancy)
            flag_mismatch($sformatf("occupancy %0d, expected %0d",
                                    res_ch.occupancy, awaited_results[0].occupancy));
          void'(awaited_results.pop_front());
        end
      end
    end
  end

  function automatic val_t pick_value();
    val_t v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = val_t'($urandom);
      // Narrow band: plenty of equal values to exercise arrival order.
      4, 5, 6:    v = val_t'(int'($urandom_range(16)) - 8);
      7: begin
        case ($urandom_range(3))
          0:       v = val_t'(32'h8000_0000);
          1:       v = val_t'(32'h7FFF_FFFF);
          2:       v = '0;
          default: v = EMPTY_VALUE;
        endcase
      end
      default:    v = val_t'($urandom);
    endcase
    return v;
  endfunction

  task automatic add_cmd(kind_e op, val_t value);
    queue_cmd_t c;
    c.op    = op;
    c.value = value;
    queued_cmds.push_back(c);
  endtask

  // Queue random commands in bursts that lean toward filling, draining or neither,
  // so both the full and the empty boundary are crossed many times.
  task automatic add_random_cmds(int unsigned count);
    int unsigned left;
    int unsigned burst;
    int unsigned enq_pct;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(40, 1);
      if (burst > left) burst = left;
      case ($urandom_range(2))
        0:       enq_pct = 80;
        1:       enq_pct = 20;
        default: enq_pct = 50;
      endcase
      repeat (burst) begin
        add_cmd(($urandom_range(99) < enq_pct) ? KIND_ENQUEUE : KIND_DEQUEUE, pick_value());
      end
      left -= burst;
    end
  endtask

  // Wait until every queued command has been offered and has come back as a result.
  task automatic wait_until_drained();
    do @(negedge clk_i);
    while (queued_cmds.size() != 0 || cmd_ch.valid || awaited_results.size() != 0);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    @(posedge clk_i);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  initial begin
    // Drive every block input to a known value from time zero.
    cmd_ch.valid      = 1'b0;
    cmd_ch.kind       = KIND_ENQUEUE;
    cmd_ch.item_value = '0;
    res_ch.ready      = 1'b0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Phase 1: sender idles often, receiver idles most of the time.
    set_idling(35, 82);
    @(negedge clk_i);
    // Dequeue from the empty queue first.
    add_cmd(KIND_DEQUEUE, val_t'($urandom));
    // Fill to capacity: extremes, alternating bit patterns and repeats.
    add_cmd(KIND_ENQUEUE, val_t'(32'h7FFF_FFFF));
    add_cmd(KIND_ENQUEUE, val_t'(32'h8000_0000));
    add_cmd(KIND_ENQUEUE, '0);
    add_cmd(KIND_ENQUEUE, EMPTY_VALUE);
    add_cmd(KIND_ENQUEUE, val_t'(1));
    add_cmd(KIND_ENQUEUE, EMPTY_VALUE);
    add_cmd(KIND_ENQUEUE, val_t'(32'h5555_5555));
    add_cmd(KIND_ENQUEUE, val_t'(32'hAAAA_AAAA));
    add_cmd(KIND_ENQUEUE, val_t'(100));
    add_cmd(KIND_ENQUEUE, val_t'(100));
    add_cmd(KIND_ENQUEUE, val_t'(-100));
    add_cmd(KIND_ENQUEUE, val_t'(7));
    add_cmd(KIND_ENQUEUE, val_t'(7));
    add_cmd(KIND_ENQUEUE, val_t'(7));
    add_cmd(KIND_ENQUEUE, val_t'(-2));
    add_cmd(KIND_ENQUEUE, val_t'(32'h4000_0000));
    // Enqueue into the full queue: dropped.
    add_cmd(KIND_ENQUEUE, val_t'(42));
    // Pull the smallest ones back out, extremes and duplicates first.
    repeat (7) add_cmd(KIND_DEQUEUE, val_t'($urandom));
    add_random_cmds(BATCH_ITEMS);
    wait_until_drained();

    // Phase 2: roles swapped.
    set_idling(82, 35);
    @(negedge clk_i);
    add_random_cmds(BATCH_ITEMS);
    wait_until_drained();

    // Phase 3: no idling, but open with a long receiver hold-off so the
    // block backs up and stalls its command input.
    set_idling(0, 0);
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    @(negedge clk_i);
    add_random_cmds(BATCH_ITEMS);
    wait_until_drained();

    // Catch any stray result beat after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3_200_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
